>>> rtl/rmp_pkg.sv
// ----------------------------------------------------------------------------
// rmp_pkg
// Shared types and constants of the region-of-interest max pooling block.
// ----------------------------------------------------------------------------
package rmp_pkg;

  localparam int unsigned StoreDepth = 16384;
  localparam int unsigned AddrW      = 14;
  localparam int unsigned QuoW       = 14;

  // Operation codes carried in the request.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POOL = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SCALE    = 3'd0;
  localparam logic [2:0] CFG_IN_H     = 3'd1;
  localparam logic [2:0] CFG_IN_W     = 3'd2;
  localparam logic [2:0] CFG_CHANNELS = 3'd3;
  localparam logic [2:0] CFG_POOL_H   = 3'd4;
  localparam logic [2:0] CFG_POOL_W   = 3'd5;

  // Coordinate selection for the shared scaling multiplier.
  localparam logic [1:0] SEL_X0 = 2'd0;
  localparam logic [1:0] SEL_Y0 = 2'd1;
  localparam logic [1:0] SEL_X1 = 2'd2;
  localparam logic [1:0] SEL_Y1 = 2'd3;

  typedef struct packed {
    logic               op;
    logic [13:0]        load_address;
    logic [15:0]        feature_value;
    logic signed [15:0] region_x_start;
    logic signed [15:0] region_y_start;
    logic signed [15:0] region_x_end;
    logic signed [15:0] region_y_end;
    logic [3:0]         channel_select;
  } rmp_in_t;

  typedef struct packed {
    logic [15:0] pooled_value;
    logic [2:0]  bin_row;
    logic [2:0]  bin_col;
    logic        last_bin;
  } rmp_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCX0,
    ST_SCY0,
    ST_SCX1,
    ST_SCY1,
    ST_SIZE,
    ST_DIVH_GO,
    ST_DIVH_WAIT,
    ST_DIVW_GO,
    ST_DIVW_WAIT,
    ST_BIN,
    ST_BIN_ADDR,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } rmp_state_e;

  typedef struct packed {
    logic       load_wr;
    logic       region_cap;
    logic       scale_en;
    logic [1:0] scale_sel;
    logic       size_en;
    logic       div_start;
    logic       div_sel_w;
    logic       div_cap;
    logic       bins_init;
    logic       edge_en;
    logic       bin_addr_en;
    logic       scan_en;
    logic       emit;
    logic       bin_advance;
  } rmp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic empty_bin;
    logic scan_last;
    logic out_free;
    logic last_row;
    logic last_col;
  } rmp_status_t;

endpackage

>>> rtl/rmp_div.sv
// ----------------------------------------------------------------------------
// rmp_div
// Restoring divider, one quotient bit per cycle, for region size by bin count.
// ----------------------------------------------------------------------------
module rmp_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rmp_pkg::QuoW-1:0] dividend_i,
  input  logic [3:0]               divisor_i,
  output logic                     done_o,
  output logic [rmp_pkg::QuoW-1:0] quotient_o,
  output logic [3:0]               remainder_o
);

  localparam int unsigned CntW = $clog2(rmp_pkg::QuoW + 1);

  logic [rmp_pkg::QuoW-1:0] quo_q, quo_d;
  logic [3:0]               rem_q, rem_d;
  logic [3:0]               dsr_q, dsr_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [4:0]               trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[rmp_pkg::QuoW-1]};
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CntW'(rmp_pkg::QuoW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so four bits plus the
      // incoming dividend bit are enough.
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = 4'(trial - {1'b0, dsr_q});
        quo_d = {quo_q[rmp_pkg::QuoW-2:0], 1'b1};
      end else begin
        rem_d = trial[3:0];
        quo_d = {quo_q[rmp_pkg::QuoW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> rtl/rmp_datapath.sv
// ----------------------------------------------------------------------------
// rmp_datapath
// Configuration, feature store, coordinate scaling, bin edges, scan and maximum.
// ----------------------------------------------------------------------------
module rmp_datapath #(
  parameter int unsigned MAX_IN_H     = 32,
  parameter int unsigned MAX_IN_W     = 32,
  parameter int unsigned MAX_CHANNELS = 16,
  parameter int unsigned MAX_POOL_H   = 8,
  parameter int unsigned MAX_POOL_W   = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  rmp_pkg::rmp_in_t     in_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output rmp_pkg::rmp_out_t    out_data_o,
  input  rmp_pkg::rmp_cmd_t    cmd_i,
  output rmp_pkg::rmp_status_t sts_o
);

  localparam int unsigned AW = rmp_pkg::AddrW;
  localparam int unsigned QW = rmp_pkg::QuoW;

  // Configuration registers.
  logic [15:0] scale_q;
  logic [5:0]  in_h_q, in_w_q;
  logic [4:0]  nch_q;
  logic [3:0]  pool_h_q, pool_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= 16'd4096;
      in_h_q   <= 6'd32;
      in_w_q   <= 6'd32;
      nch_q    <= 5'd16;
      pool_h_q <= 4'd7;
      pool_w_q <= 4'd7;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rmp_pkg::CFG_SCALE:    scale_q  <= cfg_data_i;
        rmp_pkg::CFG_IN_H:     in_h_q   <= cfg_data_i[5:0];
        rmp_pkg::CFG_IN_W:     in_w_q   <= cfg_data_i[5:0];
        rmp_pkg::CFG_CHANNELS: nch_q    <= cfg_data_i[4:0];
        rmp_pkg::CFG_POOL_H:   pool_h_q <= cfg_data_i[3:0];
        rmp_pkg::CFG_POOL_W:   pool_w_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Effective sizes after limiting to the built maxima; a pool size of zero counts as one.
  logic [5:0] ih_e, iw_e;
  logic [4:0] nch_e;
  logic [3:0] ph_e, pw_e;

  assign ih_e  = (32'(in_h_q) > MAX_IN_H) ? 6'(MAX_IN_H) : in_h_q;
  assign iw_e  = (32'(in_w_q) > MAX_IN_W) ? 6'(MAX_IN_W) : in_w_q;
  assign nch_e = (32'(nch_q) > MAX_CHANNELS) ? 5'(MAX_CHANNELS) : nch_q;
  assign ph_e  = (pool_h_q == 4'd0) ? 4'd1 :
                 ((32'(pool_h_q) > MAX_POOL_H) ? 4'(MAX_POOL_H) : pool_h_q);
  assign pw_e  = (pool_w_q == 4'd0) ? 4'd1 :
                 ((32'(pool_w_q) > MAX_POOL_W) ? 4'(MAX_POOL_W) : pool_w_q);

  // Request capture.
  logic signed [15:0] rx0_q, ry0_q, rx1_q, ry1_q;
  logic [3:0]         chan_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.region_cap) begin
      rx0_q  <= in_data_i.region_x_start;
      ry0_q  <= in_data_i.region_y_start;
      rx1_q  <= in_data_i.region_x_end;
      ry1_q  <= in_data_i.region_y_end;
      chan_q <= in_data_i.channel_select;
    end
  end

  // Coordinate scaling, one corner per cycle through one multiplier.
  logic signed [15:0] coord;
  logic signed [32:0] prod;
  logic [32:0]        mag, rsum;
  logic [12:0]        rnd;
  logic signed [13:0] scaled;
  logic signed [13:0] x0_q, y0_q, x1_q, y1_q;

  always_comb begin
    case (cmd_i.scale_sel)
      rmp_pkg::SEL_X0: coord = rx0_q;
      rmp_pkg::SEL_Y0: coord = ry0_q;
      rmp_pkg::SEL_X1: coord = rx1_q;
      default:         coord = ry1_q;
    endcase
    prod   = $signed({{17{coord[15]}}, coord}) * $signed({17'd0, scale_q});
    mag    = prod[32] ? 33'(-prod) : 33'(prod);
    rsum   = mag + 33'(20'h80000);
    rnd    = rsum[32:20];
    scaled = prod[32] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_en) begin
      case (cmd_i.scale_sel)
        rmp_pkg::SEL_X0: x0_q <= scaled;
        rmp_pkg::SEL_Y0: y0_q <= scaled;
        rmp_pkg::SEL_X1: x1_q <= scaled;
        default:         y1_q <= scaled;
      endcase
    end
  end

  // Region size, channel check and channel base address.
  logic signed [14:0] dx, dy;
  logic [QW-1:0]      rw_q, rh_q;
  logic [9:0]         cbase_q;
  logic               chan_ok_q;
  logic [AW-1:0]      base_q;
  logic [15:0]        base_full;

  assign dx        = 15'(x1_q) - 15'(x0_q) + 15'sd1;
  assign dy        = 15'(y1_q) - 15'(y0_q) + 15'sd1;
  assign base_full = 16'(cbase_q) * 16'(iw_e);

  always_ff @(posedge clk_i) begin
    if (cmd_i.size_en) begin
      rw_q      <= (dx < 15'sd1) ? QW'(1) : dx[QW-1:0];
      rh_q      <= (dy < 15'sd1) ? QW'(1) : dy[QW-1:0];
      cbase_q   <= 10'(chan_q) * 10'(ih_e);
      chan_ok_q <= {1'b0, chan_q} < nch_e;
    end
    if (cmd_i.div_start && !cmd_i.div_sel_w) begin
      base_q <= base_full[AW-1:0];
    end
  end

  // Size divided by bin count, giving whole and fractional bin steps.
  logic [QW-1:0] quo;
  logic [3:0]    rem;
  logic          div_done;
  logic [QW-1:0] qh_step_q, qw_step_q;
  logic [3:0]    rh_step_q, rw_step_q;

  rmp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (cmd_i.div_sel_w ? rw_q : rh_q),
    .divisor_i   (cmd_i.div_sel_w ? pw_e : ph_e),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_cap) begin
      if (cmd_i.div_sel_w) begin
        qw_step_q <= quo;
        rw_step_q <= rem;
      end else begin
        qh_step_q <= quo;
        rh_step_q <= rem;
      end
    end
  end

  // Bin edges: the running quotient and remainder of index times size over
  // bin count, stepped by one bin at a time.
  logic [QW-1:0] hq_q, wq_q, hq_n, wq_n;
  logic [3:0]    hr_q, wr_q, hr_n, wr_n;
  logic [4:0]    hsum, wsum;
  logic          hc, wc;
  logic [2:0]    bh_q, bw_q;

  always_comb begin
    hsum = {1'b0, hr_q} + {1'b0, rh_step_q};
    hc   = hsum >= {1'b0, ph_e};
    hr_n = hc ? 4'(hsum - {1'b0, ph_e}) : hsum[3:0];
    hq_n = hq_q + qh_step_q + QW'(hc);
    wsum = {1'b0, wr_q} + {1'b0, rw_step_q};
    wc   = wsum >= {1'b0, pw_e};
    wr_n = wc ? 4'(wsum - {1'b0, pw_e}) : wsum[3:0];
    wq_n = wq_q + qw_step_q + QW'(wc);
  end

  function automatic logic [5:0] clamp_edge(logic signed [15:0] v, logic [5:0] lim);
    logic [5:0] r;
    if (v < 16'sd0) begin
      r = 6'd0;
    end else if (v > $signed({10'd0, lim})) begin
      r = lim;
    end else begin
      r = v[5:0];
    end
    return r;
  endfunction

  logic signed [15:0] h0_raw, h1_raw, w0_raw, w1_raw;
  logic [5:0]         h0_q, h1_q, w0_q, w1_q;
  logic               empty_q;
  logic [5:0]         h0_c, h1_c, w0_c, w1_c;

  always_comb begin
    h0_raw = 16'(y0_q) + $signed({2'b0, hq_q});
    h1_raw = 16'(y0_q) + $signed({2'b0, hq_n}) + $signed(16'(hr_n != 4'd0));
    w0_raw = 16'(x0_q) + $signed({2'b0, wq_q});
    w1_raw = 16'(x0_q) + $signed({2'b0, wq_n}) + $signed(16'(wr_n != 4'd0));
    h0_c   = clamp_edge(h0_raw, ih_e);
    h1_c   = clamp_edge(h1_raw, ih_e);
    w0_c   = clamp_edge(w0_raw, iw_e);
    w1_c   = clamp_edge(w1_raw, iw_e);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_en) begin
      h0_q    <= h0_c;
      h1_q    <= h1_c;
      w0_q    <= w0_c;
      w1_q    <= w1_c;
      empty_q <= !chan_ok_q || (h1_c <= h0_c) || (w1_c <= w0_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bh_q <= '0;
      bw_q <= '0;
      hq_q <= '0;
      hr_q <= '0;
      wq_q <= '0;
      wr_q <= '0;
    end else if (cmd_i.bins_init) begin
      bh_q <= '0;
      bw_q <= '0;
      hq_q <= '0;
      hr_q <= '0;
      wq_q <= '0;
      wr_q <= '0;
    end else if (cmd_i.bin_advance) begin
      if (sts_o.last_col) begin
        bw_q <= '0;
        wq_q <= '0;
        wr_q <= '0;
        bh_q <= bh_q + 3'd1;
        hq_q <= hq_n;
        hr_q <= hr_n;
      end else begin
        bw_q <= bw_q + 3'd1;
        wq_q <= wq_n;
        wr_q <= wr_n;
      end
    end
  end

  // Scan of the bin's words, one store read per cycle.
  logic [AW-1:0] row_start, addr_q, row_q;
  logic [5:0]    x_q, y_q;
  logic          x_end, y_end;
  logic [15:0]   mem [rmp_pkg::StoreDepth];
  logic [15:0]   rdata_q;
  logic          rd_v_q;

  assign row_start = base_q + AW'(12'(h0_q) * 12'(iw_e)) + AW'(w0_q);
  assign x_end     = x_q == (w1_q - 6'd1);
  assign y_end     = y_q == (h1_q - 6'd1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.bin_addr_en) begin
      addr_q <= row_start;
      row_q  <= row_start;
      x_q    <= w0_q;
      y_q    <= h0_q;
    end else if (cmd_i.scan_en) begin
      if (x_end) begin
        x_q    <= w0_q;
        y_q    <= y_q + 6'd1;
        row_q  <= row_q + AW'(iw_e);
        addr_q <= row_q + AW'(iw_e);
      end else begin
        x_q    <= x_q + 6'd1;
        addr_q <= addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      mem[in_data_i.load_address] <= in_data_i.feature_value;
    end
    if (cmd_i.scan_en) begin
      rdata_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.scan_en;
    end
  end

  // Running maximum in a monotone key order where both zeros are equal.
  function automatic logic [15:0] order_key(logic [15:0] b);
    logic [15:0] k;
    if (b == 16'h8000) begin
      k = 16'h8000;
    end else if (b[15]) begin
      k = ~b;
    end else begin
      k = b | 16'h8000;
    end
    return k;
  endfunction

  logic [15:0] best_q;
  logic        have_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.bin_addr_en) begin
      best_q <= 16'h0000;
      have_q <= 1'b0;
    end else if (rd_v_q) begin
      if (!have_q || (order_key(rdata_q) > order_key(best_q))) begin
        best_q <= rdata_q;
      end
      have_q <= 1'b1;
    end
  end

  // Output register.
  logic              out_valid_q;
  rmp_pkg::rmp_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.pooled_value <= best_q;
      out_q.bin_row      <= bh_q;
      out_q.bin_col      <= bw_q;
      out_q.last_bin     <= sts_o.last_row && sts_o.last_col;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.div_done  = div_done;
  assign sts_o.empty_bin = empty_q;
  assign sts_o.scan_last = x_end && y_end;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.last_row  = bh_q == 3'(ph_e - 4'd1);
  assign sts_o.last_col  = bw_q == 3'(pw_e - 4'd1);

endmodule

>>> rtl/rmp_ctrl.sv
// ----------------------------------------------------------------------------
// rmp_ctrl
// Sequencer for loads and region pooling: scaling, division, bins, scan, emit.
// ----------------------------------------------------------------------------
module rmp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_op_i,
  output logic                 in_ready_o,
  input  rmp_pkg::rmp_status_t sts_i,
  output rmp_pkg::rmp_cmd_t    cmd_o
);

  rmp_pkg::rmp_state_e state_q, state_d;
  logic                in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmp_pkg::ST_IDLE: begin
        if (in_fire && (in_op_i == rmp_pkg::OP_POOL)) state_d = rmp_pkg::ST_SCX0;
      end
      rmp_pkg::ST_SCX0:     state_d = rmp_pkg::ST_SCY0;
      rmp_pkg::ST_SCY0:     state_d = rmp_pkg::ST_SCX1;
      rmp_pkg::ST_SCX1:     state_d = rmp_pkg::ST_SCY1;
      rmp_pkg::ST_SCY1:     state_d = rmp_pkg::ST_SIZE;
      rmp_pkg::ST_SIZE:     state_d = rmp_pkg::ST_DIVH_GO;
      rmp_pkg::ST_DIVH_GO:  state_d = rmp_pkg::ST_DIVH_WAIT;
      rmp_pkg::ST_DIVH_WAIT: begin
        if (sts_i.div_done) state_d = rmp_pkg::ST_DIVW_GO;
      end
      rmp_pkg::ST_DIVW_GO:  state_d = rmp_pkg::ST_DIVW_WAIT;
      rmp_pkg::ST_DIVW_WAIT: begin
        if (sts_i.div_done) state_d = rmp_pkg::ST_BIN;
      end
      rmp_pkg::ST_BIN:      state_d = rmp_pkg::ST_BIN_ADDR;
      rmp_pkg::ST_BIN_ADDR: begin
        state_d = sts_i.empty_bin ? rmp_pkg::ST_EMIT : rmp_pkg::ST_SCAN;
      end
      rmp_pkg::ST_SCAN: begin
        if (sts_i.scan_last) state_d = rmp_pkg::ST_DRAIN;
      end
      rmp_pkg::ST_DRAIN:    state_d = rmp_pkg::ST_EMIT;
      rmp_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = (sts_i.last_row && sts_i.last_col) ? rmp_pkg::ST_IDLE
                                                       : rmp_pkg::ST_BIN;
        end
      end
      default:              state_d = rmp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      rmp_pkg::ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.load_wr    = in_valid_i && (in_op_i == rmp_pkg::OP_LOAD);
        cmd_o.region_cap = in_valid_i && (in_op_i == rmp_pkg::OP_POOL);
      end
      rmp_pkg::ST_SCX0: begin
        cmd_o.scale_en  = 1'b1;
        cmd_o.scale_sel = rmp_pkg::SEL_X0;
      end
      rmp_pkg::ST_SCY0: begin
        cmd_o.scale_en  = 1'b1;
        cmd_o.scale_sel = rmp_pkg::SEL_Y0;
      end
      rmp_pkg::ST_SCX1: begin
        cmd_o.scale_en  = 1'b1;
        cmd_o.scale_sel = rmp_pkg::SEL_X1;
      end
      rmp_pkg::ST_SCY1: begin
        cmd_o.scale_en  = 1'b1;
        cmd_o.scale_sel = rmp_pkg::SEL_Y1;
      end
      rmp_pkg::ST_SIZE:     cmd_o.size_en = 1'b1;
      rmp_pkg::ST_DIVH_GO:  cmd_o.div_start = 1'b1;
      rmp_pkg::ST_DIVH_WAIT: cmd_o.div_cap = sts_i.div_done;
      rmp_pkg::ST_DIVW_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel_w = 1'b1;
      end
      rmp_pkg::ST_DIVW_WAIT: begin
        cmd_o.div_sel_w = 1'b1;
        cmd_o.div_cap   = sts_i.div_done;
        cmd_o.bins_init = sts_i.div_done;
      end
      rmp_pkg::ST_BIN:      cmd_o.edge_en = 1'b1;
      rmp_pkg::ST_BIN_ADDR: cmd_o.bin_addr_en = 1'b1;
      rmp_pkg::ST_SCAN:     cmd_o.scan_en = 1'b1;
      rmp_pkg::ST_DRAIN:    ;
      rmp_pkg::ST_EMIT: begin
        cmd_o.emit        = sts_i.out_free;
        cmd_o.bin_advance = sts_i.out_free && !(sts_i.last_row && sts_i.last_col);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_pool_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_op_i == rmp_pkg::OP_POOL) |=> state_q == rmp_pkg::ST_SCX0)
    else $error("pool request did not start scaling");

  a_last_bin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rmp_pkg::ST_EMIT) && sts_i.out_free && sts_i.last_row && sts_i.last_col
    |=> state_q == rmp_pkg::ST_IDLE)
    else $error("controller did not return to idle after the final bin");

  a_drain_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rmp_pkg::ST_DRAIN |=> state_q == rmp_pkg::ST_EMIT)
    else $error("drain not followed by emit");

endmodule

>>> rtl/roi_max_pooling_core.sv
// ----------------------------------------------------------------------------
// roi_max_pooling_core
// Region-of-interest max pooling over a channel-major half-precision store.
// ----------------------------------------------------------------------------
// Usage: a request with op load writes one feature word into the 16384-word
// store and produces no result. A request with op pool scales the four
// corners by the spatial scale, splits the region into pool_height by
// pool_width bins and returns one result per bin in row-major order, the
// final one flagged by last_bin. Configuration writes are taken at any time
// on their own channel and must only be issued while the block is idle.
// Sequence: a pool request first scales the four corners through the shared
// multiplier, sizes the region and runs two serial divisions, then for each
// bin works out its edges and start address and scans its feature words one
// at a time through the single store read port; an empty bin skips the scan.
// Requests are taken only when the sequencer is idle. Results pass through
// an output register: while the receiver stalls the sequencer waits in its
// emit step, and a new request is accepted as soon as the last result has
// been registered. Reset restores the register defaults and clears the
// control state; the store contents are undefined until written.
// ----------------------------------------------------------------------------
module roi_max_pooling_core #(
  parameter int unsigned MAX_IN_H     = 32,
  parameter int unsigned MAX_IN_W     = 32,
  parameter int unsigned MAX_CHANNELS = 16,
  parameter int unsigned MAX_POOL_H   = 8,
  parameter int unsigned MAX_POOL_W   = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rmp_pkg::rmp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rmp_pkg::rmp_out_t out_data_o
);

  rmp_pkg::rmp_cmd_t    cmd;
  rmp_pkg::rmp_status_t sts;

  assign cfg_ready_o = 1'b1;

  rmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rmp_datapath #(
    .MAX_IN_H     (MAX_IN_H),
    .MAX_IN_W     (MAX_IN_W),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_POOL_H   (MAX_POOL_H),
    .MAX_POOL_W   (MAX_POOL_W)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> verif/tb_roi_max_pooling_core.sv
// ----------------------------------------------------------------------------
// tb_roi_max_pooling_core
// Self-checking test of the region max pooling block. Loads fill the feature
// store, pool requests are predicted bin by bin and compared with the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_roi_max_pooling_core;

  localparam int unsigned WatchdogLimit = 20000;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [2:0]        cfg_index;
  logic [15:0]       cfg_data;
  logic              in_valid;
  logic              in_ready;
  rmp_pkg::rmp_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  rmp_pkg::rmp_out_t out_data;

  // Predictor state.
  logic [15:0] feat_mem [rmp_pkg::StoreDepth];
  int unsigned scale_q, map_h, map_w, chan_cnt, bins_h, bins_w;

  rmp_pkg::rmp_out_t bin_queue [$];
  int unsigned       error_count;
  int unsigned       idle_cycles;
  bit                hold_off;
  bit                gap_en;

  roi_max_pooling_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int scale_coord(logic signed [15:0] c);
    longint p;
    longint mag;
    longint r;
    p   = longint'(c) * longint'(scale_q);
    mag = (p < 0) ? -p : p;
    r   = (mag + (64'sd1 <<< 19)) >>> 20;
    return int'((p < 0) ? -r : r);
  endfunction

  function automatic int unsigned fp_key(logic [15:0] b);
    if (b == 16'h8000) b = 16'h0000;
    if (b[15]) return {16'h0, ~b};
    return {16'h0, b} | 32'h8000;
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Works out every bin of one pool request and queues the results.
  task automatic predict_bins(rmp_pkg::rmp_in_t r);
    int x0, y0, x1, y1, rw, rh, ph, pw, ih, iw, h0, h1, w0, w1, base;
    int unsigned nch, k, bkey;
    logic [13:0] a;
    logic [15:0] best;
    bit have;
    rmp_pkg::rmp_out_t o;
    x0 = scale_coord(r.region_x_start);
    y0 = scale_coord(r.region_y_start);
    x1 = scale_coord(r.region_x_end);
    y1 = scale_coord(r.region_y_end);
    rw = (x1 - x0 + 1 < 1) ? 1 : x1 - x0 + 1;
    rh = (y1 - y0 + 1 < 1) ? 1 : y1 - y0 + 1;
    ph = clip(int'(bins_h), 1, 8);
    pw = clip(int'(bins_w), 1, 8);
    ih = clip(int'(map_h), 0, 32);
    iw = clip(int'(map_w), 0, 32);
    nch = (chan_cnt > 16) ? 16 : chan_cnt;
    base = int'(r.channel_select) * ih * iw;
    for (int h = 0; h < ph; h++) begin
      for (int w = 0; w < pw; w++) begin
        h0 = clip(y0 + (h * rh) / ph, 0, ih);
        h1 = clip(y0 + ((h + 1) * rh + ph - 1) / ph, 0, ih);
        w0 = clip(x0 + (w * rw) / pw, 0, iw);
        w1 = clip(x0 + ((w + 1) * rw + pw - 1) / pw, 0, iw);
        best = 16'h0000;
        have = 1'b0;
        bkey = 0;
        if (r.channel_select < nch && h1 > h0 && w1 > w0) begin
          for (int y = h0; y < h1; y++) begin
            for (int x = w0; x < w1; x++) begin
              a = 14'(base + y * iw + x);
              k = fp_key(feat_mem[a]);
              if (!have || k > bkey) begin
                best = feat_mem[a];
                bkey = k;
                have = 1'b1;
              end
            end
          end
        end
        o.pooled_value = best;
        o.bin_row      = h[2:0];
        o.bin_col      = w[2:0];
        o.last_bin     = (h == ph - 1 && w == pw - 1);
        bin_queue.push_back(o);
      end
    end
  endtask

  // Sends one request; a random gap may precede it when idling is enabled.
  // Valid stays up after acceptance so that the next request can follow at
  // once; wait_idle and the gap drop it.
  task automatic send_request(rmp_pkg::rmp_in_t r);
    if (gap_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    if (r.op == rmp_pkg::OP_LOAD) begin
      feat_mem[r.load_address] = r.feature_value;
    end else begin
      predict_bins(r);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rmp_pkg::CFG_SCALE:    scale_q  = 32'(val);
      rmp_pkg::CFG_IN_H:     map_h    = 32'(val[5:0]);
      rmp_pkg::CFG_IN_W:     map_w    = 32'(val[5:0]);
      rmp_pkg::CFG_CHANNELS: chan_cnt = 32'(val[4:0]);
      rmp_pkg::CFG_POOL_H:   bins_h   = 32'(val[3:0]);
      rmp_pkg::CFG_POOL_W:   bins_w   = 32'(val[3:0]);
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (bin_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_map(int unsigned s, int unsigned h, int unsigned w, int unsigned c,
                         int unsigned ph, int unsigned pw);
    wait_idle();
    write_reg(rmp_pkg::CFG_SCALE, s[15:0]);
    write_reg(rmp_pkg::CFG_IN_H, h[15:0]);
    write_reg(rmp_pkg::CFG_IN_W, w[15:0]);
    write_reg(rmp_pkg::CFG_CHANNELS, c[15:0]);
    write_reg(rmp_pkg::CFG_POOL_H, ph[15:0]);
    write_reg(rmp_pkg::CFG_POOL_W, pw[15:0]);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_fp();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7C00;
      3: return 16'hFC00;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic rmp_pkg::rmp_in_t load_req(int unsigned a, logic [15:0] v);
    rmp_pkg::rmp_in_t r;
    r = '0;
    r.op = rmp_pkg::OP_LOAD;
    r.load_address = a[13:0];
    r.feature_value = v;
    return r;
  endfunction

  // Fills every channel in use of the current map.
  task automatic fill_map();
    int n;
    n = clip(int'(map_h), 0, 32) * clip(int'(map_w), 0, 32) *
        ((chan_cnt > 16) ? 16 : int'(chan_cnt));
    for (int a = 0; a < n && a < int'(rmp_pkg::StoreDepth); a++) begin
      send_request(load_req(a, rand_fp()));
    end
  endtask

  function automatic rmp_pkg::rmp_in_t pool_req(int xs, int ys, int xe, int ye,
                                                int unsigned ch);
    rmp_pkg::rmp_in_t r;
    r = '0;
    r.op = rmp_pkg::OP_POOL;
    r.region_x_start = xs[15:0];
    r.region_y_start = ys[15:0];
    r.region_x_end   = xe[15:0];
    r.region_y_end   = ye[15:0];
    r.channel_select = ch[3:0];
    return r;
  endfunction

  // Random pool request; load fields carry noise since the block ignores them.
  function automatic rmp_pkg::rmp_in_t rand_pool(int unsigned span);
    rmp_pkg::rmp_in_t r;
    r = pool_req(int'($urandom_range(0, span)) - 16, int'($urandom_range(0, span)) - 16,
                 int'($urandom_range(0, span)) - 16, int'($urandom_range(0, span)) - 16,
                 $urandom_range(0, 15));
    r.load_address  = 14'($urandom_range(0, 16383));
    r.feature_value = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 15) == 0) begin
      r.region_x_start = 16'($urandom_range(0, 65535));
      r.region_y_end   = 16'($urandom_range(0, 65535));
    end
    return r;
  endfunction

  task automatic test_directed();
    // Small map at a scale of about one sixteenth: corner regions, reversed corners, extremes.
    set_map(65535, 4, 4, 4, 8, 8);
    fill_map();
    send_request(pool_req(0, 0, 31 * 16, 31 * 16, 0));
    send_request(pool_req(16'sh7FFF, 16'sh7FFF, -32768, -32768, 15));
    send_request(pool_req(-32768, -32768, 32767, 32767, 2));
    send_request(pool_req(40, 40, 8, 8, 3));
    send_request(pool_req(-16, -16, 2 * 16, 2 * 16, 15));
    send_request(pool_req(24, 24, 24, 24, 1));
    // Pool sizes of zero and above the maximum, channel beyond the count.
    set_map(32768, 4, 4, 4, 0, 15);
    send_request(pool_req(0, 0, 62 * 16, 62 * 16, 2));
    send_request(pool_req(0, 0, 62 * 16, 62 * 16, 9));
    // Map sizes above the maximum: only the words these regions reach are set.
    set_map(1, 63, 63, 31, 1, 1);
    send_request(load_req(15 * 1024, rand_fp()));
    send_request(load_req(0, rand_fp()));
    send_request(pool_req(32767, 32767, 32767, 32767, 15));
    send_request(pool_req(-32768, 0, 32767, 0, 0));
    set_map(4096, 0, 32, 16, 3, 3);
    send_request(pool_req(0, 0, 255, 255, 0));
    set_map(4096, 32, 32, 0, 2, 2);
    send_request(pool_req(0, 0, 255, 255, 0));
  endtask

  task automatic test_random_pooling();
    int unsigned s;
    for (int phase = 0; phase < 4; phase++) begin
      s = (phase == 0) ? 65535 : $urandom_range(4096, 65535);
      set_map(s, $urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 4),
              $urandom_range(1, 8), $urandom_range(1, 8));
      fill_map();
      for (int i = 0; i < 35; i++) begin
        send_request(rand_pool(16 * 16));
      end
    end
  endtask

  task automatic test_backpressure();
    set_map(16384, 4, 4, 2, 4, 4);
    fill_map();
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_request(rand_pool(64 * 16));
    wait_idle();
  endtask

  // Receiver: random stalls, with quiet stretches and a long hold-off on demand.
  initial begin
    int unsigned hold;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        out_ready <= 1'b0;
        hold = 0;
        while (hold < 600) begin
          @(posedge clk);
          hold++;
        end
      end
      if ($urandom_range(0, 63) < 8) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker.
  initial begin
    rmp_pkg::rmp_out_t exp_bin;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (bin_queue.size() == 0) begin
          $error("result with no request outstanding: %p", out_data);
          error_count++;
        end else begin
          exp_bin = bin_queue.pop_front();
          if (out_data.pooled_value !== exp_bin.pooled_value) begin
            $error("pooled_value expected %h got %h", exp_bin.pooled_value,
                   out_data.pooled_value);
            error_count++;
          end
          if (out_data.bin_row !== exp_bin.bin_row) begin
            $error("bin_row expected %0d got %0d", exp_bin.bin_row, out_data.bin_row);
            error_count++;
          end
          if (out_data.bin_col !== exp_bin.bin_col) begin
            $error("bin_col expected %0d got %0d", exp_bin.bin_col, out_data.bin_col);
            error_count++;
          end
          if (out_data.last_bin !== exp_bin.last_bin) begin
            $error("last_bin expected %0d got %0d", exp_bin.last_bin, out_data.last_bin);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request, configuration write or result.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb_roi_max_pooling_core failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    error_count = 0;
    hold_off = 1'b0;
    gap_en = 1'b0;
    scale_q = 4096;
    map_h = 32;
    map_w = 32;
    chan_cnt = 16;
    bins_h = 7;
    bins_w = 7;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    gap_en = 1'b1;
    test_random_pooling();
    test_backpressure();
    wait_idle();
    if (error_count == 0 && bin_queue.size() == 0) begin
      $display("tb_roi_max_pooling_core passed");
    end else begin
      $display("tb_roi_max_pooling_core failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rmp_pkg.sv
rtl/rmp_div.sv
rtl/rmp_datapath.sv
rtl/rmp_ctrl.sv
rtl/roi_max_pooling_core.sv
verif/tb_roi_max_pooling_core.sv
